// File: rtl/pitt_pkg.sv
// Package: types, codes and constants of the process identity table tracker.
`default_nettype none
package pitt_pkg;

    localparam int TABLE_DEPTH = 1024;

    // operations
    localparam logic [1:0] OP_RECORD   = 2'd0;
    localparam logic [1:0] OP_LOOKUP   = 2'd1;
    localparam logic [1:0] OP_SWEEP    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // outcomes
    localparam logic [2:0] OC_UPDATED = 3'd0;
    localparam logic [2:0] OC_ADDED   = 3'd1;
    localparam logic [2:0] OC_FULL    = 3'd2;
    localparam logic [2:0] OC_SKIPPED = 3'd3;
    localparam logic [2:0] OC_HIT     = 3'd4;
    localparam logic [2:0] OC_MISS    = 3'd5;
    localparam logic [2:0] OC_SWEEP   = 3'd6;

    // entry status
    localparam logic [1:0] ST_DISCOVERED = 2'd0;
    localparam logic [1:0] ST_ACTIVE     = 2'd1;
    localparam logic [1:0] ST_TERMINATED = 2'd2;
    localparam logic [1:0] ST_EXPIRED    = 2'd3;

    // config register indexes
    localparam logic REG_MAX_ENTRIES = 1'b0;
    localparam logic REG_IDLE_TMO    = 1'b1;

    localparam logic [10:0] MAX_ENTRIES_RST = 11'd1024;

    typedef struct packed {
        logic [1:0]  operation;
        logic        first_in_snapshot;
        logic        last_in_snapshot;
        logic [22:0] pid;
        logic [47:0] start_ticks;
        logic [22:0] parent_id;
        logic [7:0]  proc_state;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [9:0]  found_index;
        logic [1:0]  found_status;
        logic [22:0] found_parent_id;
        logic [7:0]  found_proc_state;
        logic [10:0] reuse_terminated;
        logic [10:0] sweep_terminated;
        logic [10:0] sweep_expired;
        logic [10:0] active_count;
    } t_out;

    typedef struct packed {
        logic        we_key;
        logic        we_data;
        logic        we_stat;
        logic        we_seen;
        logic        we_last;
        logic [22:0] pid;
        logic [47:0] ticks;
        logic [22:0] ppid;
        logic [7:0]  pst;
        logic [1:0]  stat;
        logic        seen;
        logic [31:0] last;
    } t_tbl_wr;

    typedef struct packed {
        logic [22:0] pid;
        logic [47:0] ticks;
        logic [22:0] ppid;
        logic [7:0]  pst;
        logic [1:0]  stat;
        logic        seen;
        logic [31:0] last;
    } t_tbl_rd;

endpackage
`default_nettype wire

// File: rtl/pitt_table.sv
// Entry table: one memory per field, shared write address, one registered read port.
`default_nettype none
module pitt_table #(
    parameter int DEPTH = pitt_pkg::TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                    i_clk,
    input  wire [AW-1:0]           i_wr_addr,
    input  wire pitt_pkg::t_tbl_wr i_wr,
    input  wire [AW-1:0]           i_rd_addr,
    output pitt_pkg::t_tbl_rd      o_rd
);
    logic [22:0] m_pid   [DEPTH];
    logic [47:0] m_ticks [DEPTH];
    logic [22:0] m_ppid  [DEPTH];
    logic [7:0]  m_pst   [DEPTH];
    logic [1:0]  m_stat  [DEPTH];
    logic        m_seen  [DEPTH];
    logic [31:0] m_last  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.we_key) begin
            m_pid[i_wr_addr]   <= i_wr.pid;
            m_ticks[i_wr_addr] <= i_wr.ticks;
        end
        if (i_wr.we_data) begin
            m_ppid[i_wr_addr] <= i_wr.ppid;
            m_pst[i_wr_addr]  <= i_wr.pst;
        end
        if (i_wr.we_stat) m_stat[i_wr_addr] <= i_wr.stat;
        if (i_wr.we_seen) m_seen[i_wr_addr] <= i_wr.seen;
        if (i_wr.we_last) m_last[i_wr_addr] <= i_wr.last;
    end

    always_ff @(posedge i_clk) begin
        o_rd.pid   <= m_pid[i_rd_addr];
        o_rd.ticks <= m_ticks[i_rd_addr];
        o_rd.ppid  <= m_ppid[i_rd_addr];
        o_rd.pst   <= m_pst[i_rd_addr];
        o_rd.stat  <= m_stat[i_rd_addr];
        o_rd.seen  <= m_seen[i_rd_addr];
        o_rd.last  <= m_last[i_rd_addr];
    end
endmodule
`default_nettype wire

// File: rtl/process_identity_table_tracker.sv
// Top level: sequencer that walks the entry table for records, lookups and sweeps.
//
// channel   direction  handshake              payload
// item      in         start & !busy          i_in  (pitt_pkg::t_in)
// result    out        o_done, one cycle      o_res (pitt_pkg::t_out)
// config    in         i_cfg_valid&o_cfg_ready i_cfg_index, i_cfg_data
//
// One table port with registered read. The seen clear writes one entry a cycle;
// the other scans read an entry, then check/write it. Record: seen clear on a
// first mark, key search, reuse pass and append on a miss, sweep on a last mark
// (not after a full table), result. Lookup: key search, result. A record with no
// first mark after a full table goes straight to the result.
// Synchronous active-low reset empties the table.
// The result is shown for one cycle; the receiver cannot stall it.
`default_nettype none
module process_identity_table_tracker #(
    parameter int DEPTH = pitt_pkg::TABLE_DEPTH
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire pitt_pkg::t_in i_in,
    output logic               o_done,
    output pitt_pkg::t_out     o_res,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire                i_cfg_index,
    input  wire [31:0]         i_cfg_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_HIT   = 3'd2;
    localparam logic [2:0] S_REUSE = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_SWP   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]     r_state, n_state;
    logic           r_ph, n_ph;
    logic [CW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_act, n_act;
    logic [31:0]    r_snap, n_snap;
    logic           r_abort, n_abort;
    logic [10:0]    r_max;
    logic [31:0]    r_tmo;
    pitt_pkg::t_in  r_in, n_in;
    pitt_pkg::t_out r_res, n_res;

    pitt_pkg::t_tbl_wr wr;
    pitt_pkg::t_tbl_rd rd;
    logic [AW-1:0]     wr_addr;

    logic        at_end, key_hit;
    logic [31:0] lim32, age, idx32, cnt32, act32;
    logic [1:0]  swp_stat;

    pitt_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
        .i_clk     (i_clk),
        .i_wr_addr (wr_addr),
        .i_wr      (wr),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd      (rd)
    );

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);
    assign o_done      = (r_state == S_OUT);

    assign at_end  = (r_idx == r_cnt);
    assign key_hit = (rd.pid == r_in.pid) && (rd.ticks == r_in.start_ticks);
    assign idx32   = 32'(r_idx);
    assign cnt32   = 32'(r_cnt);
    assign act32   = 32'(r_act);
    assign lim32   = (32'(r_max) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(r_max);
    assign age     = r_snap - rd.last;

    always_comb begin
        o_res              = r_res;
        o_res.active_count = act32[10:0];
    end

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_act   = r_act;
        n_snap  = r_snap;
        n_abort = r_abort;
        n_in    = r_in;
        n_res   = r_res;
        wr       = '0;
        wr_addr  = r_idx[AW-1:0];
        wr.pid   = r_in.pid;
        wr.ticks = r_in.start_ticks;
        wr.ppid  = r_in.parent_id;
        wr.pst   = r_in.proc_state;
        wr.last  = r_snap;
        wr.stat  = pitt_pkg::ST_ACTIVE;
        wr.seen  = 1'b1;
        swp_stat = rd.stat;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in          = i_in;
                    n_res         = '0;
                    n_res.outcome = pitt_pkg::OC_SKIPPED;
                    n_idx         = '0;
                    n_ph          = 1'b0;
                    case (i_in.operation)
                        pitt_pkg::OP_LOOKUP: n_state = S_HIT;
                        pitt_pkg::OP_SWEEP: begin
                            n_snap        = i_in.now_ms;
                            n_abort       = 1'b0;
                            n_res.outcome = pitt_pkg::OC_SWEEP;
                            n_state       = S_CLR;
                        end
                        pitt_pkg::OP_RECORD: begin
                            if (i_in.first_in_snapshot) begin
                                n_snap  = i_in.now_ms;
                                n_abort = 1'b0;
                                n_state = S_CLR;
                            end else if (r_abort) begin
                                n_state = S_OUT;
                            end else begin
                                n_state = S_HIT;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_CLR: begin
                if (at_end) begin
                    n_idx   = '0;
                    n_ph    = 1'b0;
                    n_state = (r_in.operation == pitt_pkg::OP_SWEEP) ? S_SWP : S_HIT;
                end else begin
                    wr.we_seen = 1'b1;
                    wr.seen    = 1'b0;
                    n_idx      = r_idx + CW'(1);
                end
            end
            S_HIT: begin
                if (!r_ph) begin
                    if (at_end) begin
                        n_idx = '0;
                        if (r_in.operation == pitt_pkg::OP_LOOKUP) begin
                            n_res.outcome = pitt_pkg::OC_MISS;
                            n_state       = S_OUT;
                        end else begin
                            n_state = S_REUSE;
                        end
                    end else begin
                        n_ph = 1'b1;
                    end
                end else begin
                    n_ph = 1'b0;
                    if (!key_hit) begin
                        n_idx = r_idx + CW'(1);
                    end else if (r_in.operation == pitt_pkg::OP_LOOKUP) begin
                        n_res.outcome          = pitt_pkg::OC_HIT;
                        n_res.found_index      = idx32[9:0];
                        n_res.found_status     = rd.stat;
                        n_res.found_parent_id  = rd.ppid;
                        n_res.found_proc_state = rd.pst;
                        n_state                = S_OUT;
                    end else begin
                        wr.we_data = 1'b1;
                        wr.we_last = 1'b1;
                        wr.we_seen = 1'b1;
                        wr.we_stat = 1'b1;
                        if (rd.stat != pitt_pkg::ST_ACTIVE) n_act = r_act + CW'(1);
                        n_res.outcome          = pitt_pkg::OC_UPDATED;
                        n_res.found_index      = idx32[9:0];
                        n_res.found_status     = pitt_pkg::ST_ACTIVE;
                        n_res.found_parent_id  = r_in.parent_id;
                        n_res.found_proc_state = r_in.proc_state;
                        n_idx                  = '0;
                        n_state                = r_in.last_in_snapshot ? S_SWP : S_OUT;
                    end
                end
            end
            S_REUSE: begin
                if (!r_ph) begin
                    if (at_end) n_state = S_ADD;
                    else        n_ph    = 1'b1;
                end else begin
                    n_ph  = 1'b0;
                    n_idx = r_idx + CW'(1);
                    if (rd.pid == r_in.pid && rd.ticks != r_in.start_ticks &&
                        (rd.stat == pitt_pkg::ST_ACTIVE ||
                         rd.stat == pitt_pkg::ST_DISCOVERED)) begin
                        wr.we_stat = 1'b1;
                        wr.stat    = pitt_pkg::ST_TERMINATED;
                        n_res.reuse_terminated = r_res.reuse_terminated + 11'd1;
                        if (rd.stat == pitt_pkg::ST_ACTIVE) n_act = r_act - CW'(1);
                    end
                end
            end
            S_ADD: begin
                if (cnt32 >= lim32) begin
                    n_abort       = 1'b1;
                    n_res.outcome = pitt_pkg::OC_FULL;
                    n_state       = S_OUT;
                end else begin
                    wr_addr    = r_cnt[AW-1:0];
                    wr.we_key  = 1'b1;
                    wr.we_data = 1'b1;
                    wr.we_stat = 1'b1;
                    wr.we_seen = 1'b1;
                    wr.we_last = 1'b1;
                    n_cnt      = r_cnt + CW'(1);
                    n_act      = r_act + CW'(1);
                    n_res.outcome          = pitt_pkg::OC_ADDED;
                    n_res.found_index      = cnt32[9:0];
                    n_res.found_status     = pitt_pkg::ST_ACTIVE;
                    n_res.found_parent_id  = r_in.parent_id;
                    n_res.found_proc_state = r_in.proc_state;
                    n_idx                  = '0;
                    n_ph                   = 1'b0;
                    n_state                = r_in.last_in_snapshot ? S_SWP : S_OUT;
                end
            end
            S_SWP: begin
                if (!r_ph) begin
                    if (at_end) n_state = S_OUT;
                    else        n_ph    = 1'b1;
                end else begin
                    n_ph  = 1'b0;
                    n_idx = r_idx + CW'(1);
                    if (!rd.seen && (rd.stat == pitt_pkg::ST_ACTIVE ||
                                     rd.stat == pitt_pkg::ST_DISCOVERED)) begin
                        swp_stat = pitt_pkg::ST_TERMINATED;
                        n_res.sweep_terminated = r_res.sweep_terminated + 11'd1;
                        if (rd.stat == pitt_pkg::ST_ACTIVE) n_act = r_act - CW'(1);
                    end
                    // expiry sees the status left by the step above
                    if (swp_stat == pitt_pkg::ST_TERMINATED && r_tmo != 32'd0 &&
                        age >= r_tmo) begin
                        swp_stat            = pitt_pkg::ST_EXPIRED;
                        n_res.sweep_expired = n_res.sweep_expired + 11'd1;
                    end
                    wr.we_stat = 1'b1;
                    wr.stat    = swp_stat;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_act   <= '0;
            r_snap  <= '0;
            r_abort <= 1'b0;
            r_max   <= pitt_pkg::MAX_ENTRIES_RST;
            r_tmo   <= '0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_act   <= n_act;
            r_snap  <= n_snap;
            r_abort <= n_abort;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pitt_pkg::REG_MAX_ENTRIES: r_max <= i_cfg_data[10:0];
                    pitt_pkg::REG_IDLE_TMO:    r_tmo <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_res <= n_res;
    end
endmodule
`default_nettype wire

// File: rtl/pitt_checker.sv
// Port-level checker for the tracker, bound to the top level.
`default_nettype none
module pitt_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 start,
    input wire                 busy,
    input wire                 o_done,
    input wire pitt_pkg::t_out o_res
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted word did not raise busy");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result word while idle");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy) else $error("result word not single or not final");

    a_no_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_res.outcome == pitt_pkg::OC_FULL || o_res.outcome == pitt_pkg::OC_SKIPPED ||
                   o_res.outcome == pitt_pkg::OC_MISS || o_res.outcome == pitt_pkg::OC_SWEEP)
        |-> o_res.found_index == 10'd0 && o_res.found_parent_id == 23'd0)
        else $error("slot fields set without a slot");
endmodule

bind process_identity_table_tracker pitt_checker u_pitt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
`default_nettype wire

// File: verif/tb.sv
// Testbench for the process identity table tracker: scoreboard, stimulus and result checks.
module tb;

    class pid_table_sb;
        logic [22:0] e_pid [pitt_pkg::TABLE_DEPTH];
        logic [47:0] e_ticks [pitt_pkg::TABLE_DEPTH];
        logic [22:0] e_ppid [pitt_pkg::TABLE_DEPTH];
        logic [7:0]  e_pst [pitt_pkg::TABLE_DEPTH];
        logic [1:0]  e_stat [pitt_pkg::TABLE_DEPTH];
        bit          e_seen [pitt_pkg::TABLE_DEPTH];
        logic [31:0] e_last [pitt_pkg::TABLE_DEPTH];
        int unsigned n_entries;
        logic [31:0] snap_ms;
        bit          aborted;
        logic [10:0] max_ent;
        logic [31:0] idle_tmo;
        pitt_pkg::t_out pending[$];
        int          errors;

        function new();
            n_entries = 0;
            snap_ms   = 0;
            aborted   = 0;
            max_ent   = pitt_pkg::MAX_ENTRIES_RST;
            idle_tmo  = 0;
            errors    = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] d);
            if (idx == pitt_pkg::REG_MAX_ENTRIES) max_ent = d[10:0];
            else idle_tmo = d;
        endfunction

        function int find_key(logic [22:0] p, logic [47:0] t);
            for (int i = 0; i < n_entries; i++)
                if (e_pid[i] == p && e_ticks[i] == t) return i;
            return -1;
        endfunction

        function void open_snapshot(logic [31:0] now);
            for (int i = 0; i < n_entries; i++) e_seen[i] = 0;
            snap_ms = now;
            aborted = 0;
        endfunction

        function void sweep(output logic [10:0] term, output logic [10:0] expd);
            logic [31:0] age;
            term = 0;
            expd = 0;
            for (int i = 0; i < n_entries; i++) begin
                if (!e_seen[i] && (e_stat[i] == pitt_pkg::ST_ACTIVE ||
                                   e_stat[i] == pitt_pkg::ST_DISCOVERED)) begin
                    e_stat[i] = pitt_pkg::ST_TERMINATED;
                    term++;
                end
                age = snap_ms - e_last[i];
                if (e_stat[i] == pitt_pkg::ST_TERMINATED && idle_tmo != 0 &&
                    age >= idle_tmo) begin
                    e_stat[i] = pitt_pkg::ST_EXPIRED;
                    expd++;
                end
            end
        endfunction

        function void note_item(pitt_pkg::t_in x);
            pitt_pkg::t_out r;
            int hit;
            int slot;
            int unsigned lim;
            r    = '0;
            slot = -1;
            r.outcome = pitt_pkg::OC_SKIPPED;
            if (x.operation == pitt_pkg::OP_LOOKUP) begin
                slot = find_key(x.pid, x.start_ticks);
                r.outcome = (slot >= 0) ? pitt_pkg::OC_HIT : pitt_pkg::OC_MISS;
            end else if (x.operation == pitt_pkg::OP_SWEEP) begin
                open_snapshot(x.now_ms);
                sweep(r.sweep_terminated, r.sweep_expired);
                r.outcome = pitt_pkg::OC_SWEEP;
            end else if (x.operation == pitt_pkg::OP_RECORD) begin
                if (x.first_in_snapshot) open_snapshot(x.now_ms);
                if (!aborted) begin
                    hit = find_key(x.pid, x.start_ticks);
                    if (hit >= 0) begin
                        slot = hit;
                        r.outcome = pitt_pkg::OC_UPDATED;
                    end else begin
                        // pid reuse: live entries with the same pid but other ticks
                        for (int i = 0; i < n_entries; i++)
                            if (e_pid[i] == x.pid && e_ticks[i] != x.start_ticks &&
                                (e_stat[i] == pitt_pkg::ST_ACTIVE ||
                                 e_stat[i] == pitt_pkg::ST_DISCOVERED)) begin
                                e_stat[i] = pitt_pkg::ST_TERMINATED;
                                r.reuse_terminated++;
                            end
                        lim = (max_ent > pitt_pkg::TABLE_DEPTH) ? pitt_pkg::TABLE_DEPTH
                                                                 : max_ent;
                        if (n_entries >= lim) begin
                            aborted   = 1;
                            r.outcome = pitt_pkg::OC_FULL;
                        end else begin
                            slot = n_entries;
                            e_pid[slot]   = x.pid;
                            e_ticks[slot] = x.start_ticks;
                            n_entries++;
                            r.outcome = pitt_pkg::OC_ADDED;
                        end
                    end
                    if (slot >= 0) begin
                        e_ppid[slot] = x.parent_id;
                        e_pst[slot]  = x.proc_state;
                        e_last[slot] = snap_ms;
                        e_seen[slot] = 1;
                        e_stat[slot] = pitt_pkg::ST_ACTIVE;
                    end
                    if (x.last_in_snapshot && !aborted)
                        sweep(r.sweep_terminated, r.sweep_expired);
                end
            end
            if (slot >= 0) begin
                r.found_index      = slot[9:0];
                r.found_status     = e_stat[slot];
                r.found_parent_id  = e_ppid[slot];
                r.found_proc_state = e_pst[slot];
            end
            for (int i = 0; i < n_entries; i++)
                if (e_stat[i] == pitt_pkg::ST_ACTIVE) r.active_count++;
            pending.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(pitt_pkg::t_out a);
            pitt_pkg::t_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("outcome", e.outcome, a.outcome);
            cmp("found_index", e.found_index, a.found_index);
            cmp("found_status", e.found_status, a.found_status);
            cmp("found_parent_id", e.found_parent_id, a.found_parent_id);
            cmp("found_proc_state", e.found_proc_state, a.found_proc_state);
            cmp("reuse_terminated", e.reuse_terminated, a.reuse_terminated);
            cmp("sweep_terminated", e.sweep_terminated, a.sweep_terminated);
            cmp("sweep_expired", e.sweep_expired, a.sweep_expired);
            cmp("active_count", e.active_count, a.active_count);
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    pitt_pkg::t_in  i_in;
    logic           o_done;
    pitt_pkg::t_out o_res;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic           i_cfg_index;
    logic [31:0]    i_cfg_data;

    pid_table_sb sb;

    logic [22:0] key_pid [16];
    logic [47:0] key_ticks [16];
    logic [31:0] clock_ms;

    process_identity_table_tracker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_res);
    end

    function automatic pitt_pkg::t_in mk(logic [1:0] op, logic f, logic l, logic [22:0] p,
                                         logic [47:0] t, logic [22:0] pp, logic [7:0] ps,
                                         logic [31:0] now);
        pitt_pkg::t_in x;
        x.operation         = op;
        x.first_in_snapshot = f;
        x.last_in_snapshot  = l;
        x.pid               = p;
        x.start_ticks       = t;
        x.parent_id         = pp;
        x.proc_state        = ps;
        x.now_ms            = now;
        return x;
    endfunction

    task automatic send_item(pitt_pkg::t_in x, int pct);
        int gap;
        gap = ($urandom_range(99) < pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= x;
        do @(posedge i_clk); while (busy);
        sb.note_item(x);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] d);
        drain();
        sb.set_reg(idx, d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [47:0] rnd48();
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic run_random(int n, int pct);
        int sent;
        int r;
        int len;
        int k;
        pitt_pkg::t_in x;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 3) drain();
            if (r < 70) begin
                len = $urandom_range(1, 6);
                clock_ms += $urandom_range(1, 400);
                for (int j = 0; j < len; j++) begin
                    k = $urandom_range(15);
                    send_item(mk(pitt_pkg::OP_RECORD, j == 0, j == len - 1, key_pid[k],
                                 key_ticks[k], 23'($urandom()), 8'($urandom()), clock_ms),
                              pct);
                end
                sent += len;
            end else if (r < 85) begin
                k = $urandom_range(15);
                x = mk(pitt_pkg::OP_LOOKUP, 1'($urandom()), 1'($urandom()), key_pid[k],
                       key_ticks[k], 23'($urandom()), 8'($urandom()), $urandom());
                if ($urandom_range(3) == 0) x.start_ticks = rnd48();
                send_item(x, pct);
                sent++;
            end else begin
                // noise: any operation, any marks, fresh keys or known pids and keys
                x = mk(2'($urandom()), 1'($urandom()), 1'($urandom()), 23'($urandom()),
                       rnd48(), 23'($urandom()), 8'($urandom()), $urandom());
                if ($urandom_range(1) == 0) begin
                    k = $urandom_range(15);
                    x.pid = key_pid[k];
                    if ($urandom_range(1) == 0) x.start_ticks = key_ticks[k];
                end
                send_item(x, pct);
                sent++;
            end
        end
    endtask

    initial begin
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = pitt_pkg::REG_MAX_ENTRIES;
        i_cfg_data  = '0;
        clock_ms    = 32'hFFFF_FC00;
        for (int k = 0; k < 16; k++) begin
            key_pid[k]   = (k % 4 == 1) ? key_pid[k - 1] : 23'($urandom());
            key_ticks[k] = rnd48();
        end
        key_pid[15] = 23'h7FFFFF;
        key_ticks[15] = '1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every operation, reuse, full table and skip
        send_item(mk(pitt_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 0);
        send_item(mk(pitt_pkg::OP_SWEEP, 0, 0, 0, 0, 0, 0, 0), 0);
        send_item(mk(pitt_pkg::OP_RECORD, 1, 1, 23'h7FFFFF, '1, 23'h7FFFFF, 8'hFF, '1), 0);
        send_item(mk(pitt_pkg::OP_RECORD, 1, 0, 0, 0, 1, 8'h52, 32'd5), 0);
        send_item(mk(pitt_pkg::OP_RECORD, 0, 0, 0, 1, 2, 8'h53, 32'd6), 0);
        send_item(mk(pitt_pkg::OP_RECORD, 0, 0, 0, 0, 3, 8'h5A, 32'd7), 0);
        send_item(mk(pitt_pkg::OP_LOOKUP, 1, 1, 0, 0, 0, 0, 0), 0);
        send_item(mk(pitt_pkg::OP_LOOKUP, 0, 0, 0, 2, 0, 0, 0), 0);
        send_item(mk(pitt_pkg::OP_RESERVED, 1, 1, 0, 0, 0, 0, 0), 0);
        send_item(mk(pitt_pkg::OP_RECORD, 0, 1, 5, 9, 0, 8'h53, 32'd8), 0);
        drain();
        write_reg(pitt_pkg::REG_IDLE_TMO, 32'd1);
        write_reg(pitt_pkg::REG_MAX_ENTRIES, 32'd0);
        send_item(mk(pitt_pkg::OP_RECORD, 1, 0, 5, 10, 0, 0, 32'd20), 0);
        send_item(mk(pitt_pkg::OP_RECORD, 0, 1, 0, 0, 0, 0, 32'd21), 0);
        send_item(mk(pitt_pkg::OP_RECORD, 1, 1, 0, 0, 4, 8'h01, 32'd30), 0);
        send_item(mk(pitt_pkg::OP_SWEEP, 1, 1, 0, 0, 0, 0, 32'd40), 0);
        send_item(mk(pitt_pkg::OP_SWEEP, 0, 0, 0, 0, 0, 0, '1), 0);

        write_reg(pitt_pkg::REG_MAX_ENTRIES, 32'd12);
        write_reg(pitt_pkg::REG_IDLE_TMO, 32'd600);
        run_random(95, 26);
        write_reg(pitt_pkg::REG_MAX_ENTRIES, 32'd2047);
        write_reg(pitt_pkg::REG_IDLE_TMO, 32'hFFFF_FFFF);
        run_random(95, 70);
        write_reg(pitt_pkg::REG_MAX_ENTRIES, 32'd1024);
        write_reg(pitt_pkg::REG_IDLE_TMO, 32'd250);
        run_random(90, 0);

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/pitt_pkg.sv
rtl/pitt_table.sv
rtl/process_identity_table_tracker.sv
rtl/pitt_checker.sv
verif/tb.sv
